FILE: rtl/core/uvs_pkg.sv
`default_nettype none

package uvs_pkg;

  // Field and count widths.
  localparam int unsigned CntW    = 11;
  localparam int unsigned IdxW    = 21;
  localparam int unsigned TexW    = 17;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned PhaseW  = 32;
  localparam int unsigned CfgAddrW = 2;

  localparam logic [CntW-1:0] MaxSlices = 11'd1024;
  localparam logic [CntW-1:0] MaxStacks = 11'd1024;
  localparam logic [CntW-1:0] MinSlices = 11'd3;
  localparam logic [CntW-1:0] MinStacks = 11'd2;
  localparam logic [CntW-1:0] CountReset = 11'd16;

  localparam int unsigned FracBits = 14;

  // Long division: 33 quotient bits out of a 44-bit dividend.
  localparam int unsigned DivSteps = 33;
  localparam int unsigned DvdW     = 44;
  localparam int unsigned DivLanes = 4;

  // Rotation-mode CORDIC in Q.30.
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned CordicW     = 33;
  localparam logic signed [CordicW-1:0] CordicGainInv = 33'sd652032874;

  localparam logic [31:0] ATAN_TURNS [CordicSteps] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  typedef enum logic [CfgAddrW-1:0] {
    REG_SLICE_COUNT = 2'd0,
    REG_STACK_COUNT = 2'd1
  } cfg_reg_e;

  // Data that travels alongside the arithmetic.
  typedef struct packed {
    logic            quad_valid;
    logic [IdxW-1:0] lo;
    logic [IdxW-1:0] hi;
    logic [TexW-1:0] tex_u;
    logic [TexW-1:0] tex_v;
  } side_t;

  typedef struct packed {
    logic [CntW-1:0]     rem;
    logic [DivSteps-1:0] bits;
    logic [DivSteps-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic signed [PhaseW-1:0]  z;
    logic [1:0]                quad;
  } cordic_t;

  function automatic logic [CntW-1:0] clamp_cnt(logic [CntW-1:0] v, logic [CntW-1:0] lo,
                                                logic [CntW-1:0] hi);
    logic [CntW-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // One restoring division step: bring in the next dividend bit.
  function automatic div_lane_t div_step(div_lane_t l, logic [CntW-1:0] d);
    logic [CntW:0] t;
    logic          ge;
    div_lane_t     r;
    t      = {l.rem, l.bits[DivSteps-1]};
    ge     = (t >= {1'b0, d});
    r.rem  = ge ? CntW'(t - {1'b0, d}) : t[CntW-1:0];
    r.bits = {l.bits[DivSteps-2:0], 1'b0};
    r.quo  = {l.quo[DivSteps-2:0], ge};
    return r;
  endfunction

  // One CORDIC micro-rotation; arithmetic shifts round toward minus infinity.
  function automatic cordic_t cordic_step(cordic_t c, logic [4:0] i);
    logic signed [CordicW-1:0] dx;
    logic signed [CordicW-1:0] dy;
    logic signed [PhaseW-1:0]  ang;
    cordic_t                   r;
    dx     = c.y >>> i;
    dy     = c.x >>> i;
    ang    = $signed(ATAN_TURNS[i]);
    r.quad = c.quad;
    if (!c.z[PhaseW-1]) begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - ang;
    end else begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + ang;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/uv_sphere_vertex_generator.sv
`default_nettype none

// UV sphere vertex generator. Each item names one grid point (stack row, slice column)
// and yields one result: the unit-sphere position in signed Q2.14, the texture
// coordinates in Q1.16 and, where the point starts a quad, that quad's six
// triangle-list indices. The block takes a new item in every clock cycle and busy
// stays low; each result appears for exactly one cycle, marked by result_valid_o,
// and the receiver cannot hold it off. The pipeline is made of a 33-stage long
// divider that turns the grid point into angles and texture coordinates, a 30-stage
// CORDIC rotator for the sines and cosines, two input stages and three output
// stages. The slice and stack counts are written through the configuration port,
// which is always ready, and must only change while no item is in flight. Counts
// outside their legal ranges are clamped when used, and grid indices beyond the
// counts are clamped to the counts.

module uv_sphere_vertex_generator (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start,
  output logic                                 busy,
  input  wire [uvs_pkg::CntW-1:0]              stack_row_i,
  input  wire [uvs_pkg::CntW-1:0]              slice_column_i,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire [uvs_pkg::CfgAddrW-1:0]          cfg_addr_i,
  input  wire [uvs_pkg::CntW-1:0]              cfg_wdata_i,
  output logic                                 result_valid_o,
  output logic signed [uvs_pkg::CoordW-1:0]    pos_x_o,
  output logic signed [uvs_pkg::CoordW-1:0]    pos_y_o,
  output logic signed [uvs_pkg::CoordW-1:0]    pos_z_o,
  output logic [uvs_pkg::TexW-1:0]             tex_u_o,
  output logic [uvs_pkg::TexW-1:0]             tex_v_o,
  output logic                                 quad_valid_o,
  output logic [uvs_pkg::IdxW-1:0]             tri_index_0_o,
  output logic [uvs_pkg::IdxW-1:0]             tri_index_1_o,
  output logic [uvs_pkg::IdxW-1:0]             tri_index_2_o,
  output logic [uvs_pkg::IdxW-1:0]             tri_index_3_o,
  output logic [uvs_pkg::IdxW-1:0]             tri_index_4_o,
  output logic [uvs_pkg::IdxW-1:0]             tri_index_5_o
);

  // The pipeline never stalls, so the block is never busy and configuration
  // writes are always taken.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers. Writes to indices beyond the list are dropped.
  logic [uvs_pkg::CntW-1:0] slice_count_q;
  logic [uvs_pkg::CntW-1:0] stack_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_count_q <= uvs_pkg::CountReset;
      stack_count_q <= uvs_pkg::CountReset;
    end else if (cfg_valid_i) begin
      unique case (uvs_pkg::cfg_reg_e'(cfg_addr_i))
        uvs_pkg::REG_SLICE_COUNT: slice_count_q <= cfg_wdata_i;
        uvs_pkg::REG_STACK_COUNT: stack_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The counts as they are used: clamped to their legal ranges.
  logic [uvs_pkg::CntW-1:0] slices_c;
  logic [uvs_pkg::CntW-1:0] stacks_c;

  assign slices_c = uvs_pkg::clamp_cnt(slice_count_q, uvs_pkg::MinSlices, uvs_pkg::MaxSlices);
  assign stacks_c = uvs_pkg::clamp_cnt(stack_count_q, uvs_pkg::MinStacks, uvs_pkg::MaxStacks);

  // Input stage: take the item and clamp the grid indices to the counts.
  logic                     accept;
  logic                     v1_q;
  logic [uvs_pkg::CntW-1:0] st1_q;
  logic [uvs_pkg::CntW-1:0] sl1_q;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    st1_q <= (stack_row_i > stacks_c) ? stacks_c : stack_row_i;
    sl1_q <= (slice_column_i > slices_c) ? slices_c : slice_column_i;
  end

  // Second stage: vertex indices of the quad (one 11 by 11 multiply) and the
  // four dividends for the angle and texture divisions. The stack angle is in
  // units of a half turn over the stacks, the slice angle a full turn over the
  // slices; the texture dividends carry half the divisor for rounding.
  logic [uvs_pkg::CntW-1:0] k_c;
  logic [uvs_pkg::IdxW-1:0] lo_c;
  logic [uvs_pkg::IdxW-1:0] hi_c;
  logic                     quad_c;

  assign k_c    = uvs_pkg::CntW'(slices_c + 1'b1);
  assign lo_c   = uvs_pkg::IdxW'(st1_q) * uvs_pkg::IdxW'(k_c) + uvs_pkg::IdxW'(sl1_q);
  assign hi_c   = lo_c + uvs_pkg::IdxW'(k_c);
  assign quad_c = (st1_q < stacks_c) && (sl1_q < slices_c);

  logic                     v2_q;
  uvs_pkg::side_t           side2_q;
  logic [uvs_pkg::DvdW-1:0] dvd_pa_q;
  logic [uvs_pkg::DvdW-1:0] dvd_pt_q;
  logic [uvs_pkg::DvdW-1:0] dvd_u_q;
  logic [uvs_pkg::DvdW-1:0] dvd_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side2_q.quad_valid <= quad_c;
    side2_q.lo         <= lo_c;
    side2_q.hi         <= hi_c;
    side2_q.tex_u      <= '0;
    side2_q.tex_v      <= '0;
    dvd_pa_q <= {2'b00, st1_q, 31'b0};
    dvd_pt_q <= {1'b0, sl1_q, 32'b0};
    dvd_u_q  <= {17'b0, sl1_q, 16'b0} + uvs_pkg::DvdW'(slices_c >> 1);
    dvd_v_q  <= {17'b0, st1_q, 16'b0} + uvs_pkg::DvdW'(stacks_c >> 1);
  end

  // Long division, one quotient bit per stage in all four lanes at once.
  logic                       v3_valid;
  uvs_pkg::side_t             side3;
  logic [uvs_pkg::PhaseW-1:0] phase_a;
  logic [uvs_pkg::PhaseW-1:0] phase_t;

  uvs_div_pipe u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (v2_q),
    .side_i    (side2_q),
    .dvd_pa_i  (dvd_pa_q),
    .dvd_pt_i  (dvd_pt_q),
    .dvd_u_i   (dvd_u_q),
    .dvd_v_i   (dvd_v_q),
    .slices_i  (slices_c),
    .stacks_i  (stacks_c),
    .valid_o   (v3_valid),
    .side_o    (side3),
    .phase_a_o (phase_a),
    .phase_t_o (phase_t)
  );

  // Sine and cosine of both angles, one micro-rotation per stage.
  logic             v4_valid;
  uvs_pkg::side_t   side4;
  uvs_pkg::cordic_t rot_a;
  uvs_pkg::cordic_t rot_t;

  uvs_cordic_pipe u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (v3_valid),
    .side_i    (side3),
    .phase_a_i (phase_a),
    .phase_t_i (phase_t),
    .valid_o   (v4_valid),
    .side_o    (side4),
    .rot_a_o   (rot_a),
    .rot_t_o   (rot_t)
  );

  // Quadrant correction, products, rounding and the result register.
  uvs_coord_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (v4_valid),
    .side_i        (side4),
    .rot_a_i       (rot_a),
    .rot_t_i       (rot_t),
    .valid_o       (result_valid_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .tex_u_o       (tex_u_o),
    .tex_v_o       (tex_v_o),
    .quad_valid_o  (quad_valid_o),
    .tri_index_0_o (tri_index_0_o),
    .tri_index_1_o (tri_index_1_o),
    .tri_index_2_o (tri_index_2_o),
    .tri_index_3_o (tri_index_3_o),
    .tri_index_4_o (tri_index_4_o),
    .tri_index_5_o (tri_index_5_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/uvs_div_pipe.sv
`default_nettype none

module uvs_div_pipe (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           valid_i,
  input  uvs_pkg::side_t                side_i,
  input  wire [uvs_pkg::DvdW-1:0]       dvd_pa_i,
  input  wire [uvs_pkg::DvdW-1:0]       dvd_pt_i,
  input  wire [uvs_pkg::DvdW-1:0]       dvd_u_i,
  input  wire [uvs_pkg::DvdW-1:0]       dvd_v_i,
  input  wire [uvs_pkg::CntW-1:0]       slices_i,
  input  wire [uvs_pkg::CntW-1:0]       stacks_i,
  output logic                          valid_o,
  output uvs_pkg::side_t                side_o,
  output logic [uvs_pkg::PhaseW-1:0]    phase_a_o,
  output logic [uvs_pkg::PhaseW-1:0]    phase_t_o
);

  // Lanes: 0 stack phase, 1 slice phase, 2 texture u, 3 texture v.
  uvs_pkg::div_lane_t lane_init [uvs_pkg::DivLanes];
  uvs_pkg::div_lane_t lane_q    [uvs_pkg::DivSteps][uvs_pkg::DivLanes];
  uvs_pkg::side_t     side_q    [uvs_pkg::DivSteps];
  logic               valid_q   [uvs_pkg::DivSteps];
  logic [uvs_pkg::DvdW-1:0] dvd [uvs_pkg::DivLanes];

  assign dvd[0] = dvd_pa_i;
  assign dvd[1] = dvd_pt_i;
  assign dvd[2] = dvd_u_i;
  assign dvd[3] = dvd_v_i;

  // The quotient fits in 33 bits, so the top of the dividend is already below the divisor.
  for (genvar l = 0; l < uvs_pkg::DivLanes; l++) begin : g_init
    always_comb begin
      lane_init[l].rem  = dvd[l][uvs_pkg::DvdW-1:uvs_pkg::DivSteps];
      lane_init[l].bits = dvd[l][uvs_pkg::DivSteps-1:0];
      lane_init[l].quo  = '0;
    end
  end

  for (genvar s = 0; s < uvs_pkg::DivSteps; s++) begin : g_stage
    for (genvar l = 0; l < uvs_pkg::DivLanes; l++) begin : g_lane
      logic [uvs_pkg::CntW-1:0] divisor;
      assign divisor = (l == 1 || l == 2) ? slices_i : stacks_i;
      if (s == 0) begin : g_first
        always_ff @(posedge clk_i) begin
          lane_q[s][l] <= uvs_pkg::div_step(lane_init[l], divisor);
        end
      end else begin : g_next
        always_ff @(posedge clk_i) begin
          lane_q[s][l] <= uvs_pkg::div_step(lane_q[s-1][l], divisor);
        end
      end
    end
    if (s == 0) begin : g_side_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[s] <= 1'b0;
        end else begin
          valid_q[s] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        side_q[s] <= side_i;
      end
    end else begin : g_side_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[s] <= 1'b0;
        end else begin
          valid_q[s] <= valid_q[s-1];
        end
      end
      always_ff @(posedge clk_i) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  localparam int unsigned Last = uvs_pkg::DivSteps - 1;

  always_comb begin
    side_o       = side_q[Last];
    side_o.tex_u = lane_q[Last][2].quo[uvs_pkg::TexW-1:0];
    side_o.tex_v = uvs_pkg::TexW'(17'd65536 - lane_q[Last][3].quo[uvs_pkg::TexW-1:0]);
  end

  assign valid_o   = valid_q[Last];
  assign phase_a_o = lane_q[Last][0].quo[uvs_pkg::PhaseW-1:0];
  assign phase_t_o = lane_q[Last][1].quo[uvs_pkg::PhaseW-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/uvs_cordic_pipe.sv
`default_nettype none

module uvs_cordic_pipe (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        valid_i,
  input  uvs_pkg::side_t             side_i,
  input  wire [uvs_pkg::PhaseW-1:0]  phase_a_i,
  input  wire [uvs_pkg::PhaseW-1:0]  phase_t_i,
  output logic                       valid_o,
  output uvs_pkg::side_t             side_o,
  output uvs_pkg::cordic_t           rot_a_o,
  output uvs_pkg::cordic_t           rot_t_o
);

  uvs_pkg::cordic_t rot_init [2];
  uvs_pkg::cordic_t rot_q    [uvs_pkg::CordicSteps][2];
  uvs_pkg::side_t   side_q   [uvs_pkg::CordicSteps];
  logic             valid_q  [uvs_pkg::CordicSteps];
  logic [uvs_pkg::PhaseW-1:0] phase [2];

  assign phase[0] = phase_a_i;
  assign phase[1] = phase_t_i;

  // Rotate within the quadrant; the quadrant itself is applied afterwards.
  for (genvar l = 0; l < 2; l++) begin : g_init
    always_comb begin
      rot_init[l].x    = uvs_pkg::CordicGainInv;
      rot_init[l].y    = '0;
      rot_init[l].z    = $signed({2'b00, phase[l][uvs_pkg::PhaseW-3:0]});
      rot_init[l].quad = phase[l][uvs_pkg::PhaseW-1:uvs_pkg::PhaseW-2];
    end
  end

  for (genvar s = 0; s < uvs_pkg::CordicSteps; s++) begin : g_stage
    for (genvar l = 0; l < 2; l++) begin : g_lane
      if (s == 0) begin : g_first
        always_ff @(posedge clk_i) begin
          rot_q[s][l] <= uvs_pkg::cordic_step(rot_init[l], 5'(s));
        end
      end else begin : g_next
        always_ff @(posedge clk_i) begin
          rot_q[s][l] <= uvs_pkg::cordic_step(rot_q[s-1][l], 5'(s));
        end
      end
    end
    if (s == 0) begin : g_side_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[s] <= 1'b0;
        end else begin
          valid_q[s] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        side_q[s] <= side_i;
      end
    end else begin : g_side_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[s] <= 1'b0;
        end else begin
          valid_q[s] <= valid_q[s-1];
        end
      end
      always_ff @(posedge clk_i) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = valid_q[uvs_pkg::CordicSteps-1];
  assign side_o  = side_q[uvs_pkg::CordicSteps-1];
  assign rot_a_o = rot_q[uvs_pkg::CordicSteps-1][0];
  assign rot_t_o = rot_q[uvs_pkg::CordicSteps-1][1];

endmodule

`default_nettype wire

FILE: rtl/core/uvs_coord_out.sv
`default_nettype none

module uvs_coord_out (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               valid_i,
  input  uvs_pkg::side_t                    side_i,
  input  uvs_pkg::cordic_t                  rot_a_i,
  input  uvs_pkg::cordic_t                  rot_t_i,
  output logic                              valid_o,
  output logic signed [uvs_pkg::CoordW-1:0] pos_x_o,
  output logic signed [uvs_pkg::CoordW-1:0] pos_y_o,
  output logic signed [uvs_pkg::CoordW-1:0] pos_z_o,
  output logic [uvs_pkg::TexW-1:0]          tex_u_o,
  output logic [uvs_pkg::TexW-1:0]          tex_v_o,
  output logic                              quad_valid_o,
  output logic [uvs_pkg::IdxW-1:0]          tri_index_0_o,
  output logic [uvs_pkg::IdxW-1:0]          tri_index_1_o,
  output logic [uvs_pkg::IdxW-1:0]          tri_index_2_o,
  output logic [uvs_pkg::IdxW-1:0]          tri_index_3_o,
  output logic [uvs_pkg::IdxW-1:0]          tri_index_4_o,
  output logic [uvs_pkg::IdxW-1:0]          tri_index_5_o
);

  localparam int unsigned Shift = 60 - uvs_pkg::FracBits;
  localparam logic signed [63:0] RoundBias = 64'sd1 <<< (Shift - 1);
  localparam logic signed [63:0] Lim       = 64'sd1 <<< uvs_pkg::FracBits;

  function automatic logic [uvs_pkg::CoordW-1:0] to_coord(logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + RoundBias) >>> Shift;
    if (r > Lim) begin
      r = Lim;
    end else if (r < -Lim) begin
      r = -Lim;
    end
    return uvs_pkg::CoordW'(r);
  endfunction

  // Quadrant correction: returns cosine in the upper half, sine in the lower.
  function automatic logic [63:0] apply_quad(uvs_pkg::cordic_t c);
    logic signed [uvs_pkg::CordicW-1:0] co;
    logic signed [uvs_pkg::CordicW-1:0] si;
    case (c.quad)
      2'd0: begin
        co = c.x;
        si = c.y;
      end
      2'd1: begin
        co = -c.y;
        si = c.x;
      end
      2'd2: begin
        co = -c.x;
        si = -c.y;
      end
      default: begin
        co = c.y;
        si = -c.x;
      end
    endcase
    return {co[31:0], si[31:0]};
  endfunction

  logic [63:0] cs_a;
  logic [63:0] cs_t;

  assign cs_a = apply_quad(rot_a_i);
  assign cs_t = apply_quad(rot_t_i);

  // Stage 1: quadrant applied, sine of the stack angle negated.
  logic signed [31:0] ca_q, nsa_q, ct_q, stt_q;
  logic               v1_q;
  uvs_pkg::side_t     side1_q;

  always_ff @(posedge clk_i) begin
    ca_q    <= $signed(cs_a[63:32]);
    nsa_q   <= 32'(-$signed(cs_a[31:0]));
    ct_q    <= $signed(cs_t[63:32]);
    stt_q   <= $signed(cs_t[31:0]);
    side1_q <= side_i;
  end

  // Stage 2: exact Q.60 products.
  logic signed [63:0] px_q, py_q, pz_q;
  logic               v2_q;
  uvs_pkg::side_t     side2_q;

  always_ff @(posedge clk_i) begin
    px_q    <= nsa_q * stt_q;
    py_q    <= $signed({{2{ca_q[31]}}, ca_q, 30'b0});
    pz_q    <= nsa_q * ct_q;
    side2_q <= side1_q;
  end

  // Stage 3: rounding, saturation and the index pattern of the quad.
  logic [uvs_pkg::IdxW-1:0] lo_p1;
  logic [uvs_pkg::IdxW-1:0] hi_p1;

  assign lo_p1 = side2_q.lo + 1'b1;
  assign hi_p1 = side2_q.hi + 1'b1;

  always_ff @(posedge clk_i) begin
    pos_x_o      <= $signed(to_coord(px_q));
    pos_y_o      <= $signed(to_coord(py_q));
    pos_z_o      <= $signed(to_coord(pz_q));
    tex_u_o      <= side2_q.tex_u;
    tex_v_o      <= side2_q.tex_v;
    quad_valid_o <= side2_q.quad_valid;
    if (side2_q.quad_valid) begin
      tri_index_0_o <= hi_p1;
      tri_index_1_o <= side2_q.lo;
      tri_index_2_o <= side2_q.hi;
      tri_index_3_o <= side2_q.lo;
      tri_index_4_o <= hi_p1;
      tri_index_5_o <= lo_p1;
    end else begin
      tri_index_0_o <= '0;
      tri_index_1_o <= '0;
      tri_index_2_o <= '0;
      tri_index_3_o <= '0;
      tri_index_4_o <= '0;
      tri_index_5_o <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      valid_o <= v2_q;
    end
  end

endmodule

`default_nettype wire
